>>> hw/rtl/clvr_pkg.sv
// ----------------------------------------------------------------------------
// clvr_pkg: shared types and constants for the clamped linear value ramp
// Command codes, register indexes, controller states and reset defaults.
// ----------------------------------------------------------------------------
package clvr_pkg;

    // Default datapath widths
    localparam int VALUE_BITS_DEF = 16;
    localparam int FRAME_BITS_DEF = 16;

    // Register reset values, Q8.8: -24.0, +24.0, 0.0
    localparam int MIN_RESET   = -6144;
    localparam int MAX_RESET   = 6144;
    localparam int VALUE_RESET = 0;

    // Item commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_RESET = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_MIN         = 2'd0,
        REG_MAX         = 2'd1,
        REG_RESET_VALUE = 2'd2
    } reg_idx_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_CALC   = 2'd1,
        ST_RESULT = 2'd2
    } state_t;

endpackage

>>> hw/rtl/clamped_linear_value_ramp_top.sv
// Sequence: an accepted set, stop or reset, or a tick that ends or has no ramp,
//   goes from IDLE to RESULT; a tick inside a ramp goes through CALC, where the
//   bit-serial scaler takes one bit of mag a cycle, before RESULT.
// Throughput: one transaction at a time; the next is taken once the last result
//   is in the output register.
// Reset: rst_n async, low; registers return to -24.0 / +24.0 / 0.0, value 0.
// ----------------------------------------------------------------------------
// clamped_linear_value_ramp_top: fader for one signed Q8.8 control value
// Tick, set (clamped, jump or ramp), stop and reset commands, one result per
// transaction with the value after it and the ramp status.
// ----------------------------------------------------------------------------
module clamped_linear_value_ramp_top #(
    parameter int VALUE_BITS = clvr_pkg::VALUE_BITS_DEF,
    parameter int FRAME_BITS = clvr_pkg::FRAME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic signed [VALUE_BITS-1:0] request_value,
    input  logic [FRAME_BITS-1:0]        ramp_frames,
    // Output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] current_value,
    output logic                         ramping,
    // Configuration
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [VALUE_BITS-1:0]        cfg_wdata
);

    clvr_pkg::state_t state_reg, state_next;

    logic signed [VALUE_BITS-1:0] min_reg, max_reg, rstv_reg;
    logic signed [VALUE_BITS-1:0] present_reg, present_next;
    logic signed [VALUE_BITS-1:0] start_reg, start_next;
    logic signed [VALUE_BITS-1:0] target_reg, target_next;
    logic [FRAME_BITS-1:0]        len_reg, len_next;
    logic [FRAME_BITS-1:0]        fc_reg, fc_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [VALUE_BITS-1:0] out_value_reg;
    logic                         out_ramp_reg;

    logic                  accept;
    logic                  load_out;
    logic                  scl_start;
    logic                  scl_done;
    logic [VALUE_BITS-1:0] scl_quot;
    clvr_pkg::cmd_t        cmd;

    logic                         running;
    logic [FRAME_BITS-1:0]        fc_inc;
    logic                         need_div;
    logic signed [VALUE_BITS:0]   diff;
    logic                         neg;
    logic [VALUE_BITS:0]          mag_full;
    logic signed [VALUE_BITS-1:0] clamped;

    assign cmd    = clvr_pkg::cmd_t'(command);
    assign accept = in_valid && !in_stall;

    // Ramp bookkeeping
    always_comb
    begin
        running  = fc_reg < len_reg;
        fc_inc   = fc_reg + FRAME_BITS'(1);
        need_div = running && (fc_inc != len_reg);
        diff     = {target_reg[VALUE_BITS-1], target_reg} - {start_reg[VALUE_BITS-1], start_reg};
        neg      = diff[VALUE_BITS];
        mag_full = neg ? -diff : diff;
    end

    // Clamp of the requested value; the max test wins over the min test
    always_comb
    begin
        if (request_value > max_reg)
        begin
            clamped = max_reg;
        end
        else if (request_value < min_reg)
        begin
            clamped = min_reg;
        end
        else
        begin
            clamped = request_value;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clvr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd == clvr_pkg::CMD_TICK && need_div) ?
                                 clvr_pkg::ST_CALC : clvr_pkg::ST_RESULT;
                end
            end
            clvr_pkg::ST_CALC:
            begin
                if (scl_done)
                begin
                    state_next = clvr_pkg::ST_RESULT;
                end
            end
            clvr_pkg::ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = clvr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clvr_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_stall  = 1'b1;
        load_out  = 1'b0;
        scl_start = 1'b0;
        unique case (state_reg)
            clvr_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                scl_start = in_valid && cmd == clvr_pkg::CMD_TICK && need_div;
            end
            clvr_pkg::ST_CALC:
            begin
                in_stall = 1'b1;
            end
            clvr_pkg::ST_RESULT:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Ramp state update
    always_comb
    begin
        present_next = present_reg;
        start_next   = start_reg;
        target_next  = target_reg;
        len_next     = len_reg;
        fc_next      = fc_reg;
        if (accept)
        begin
            unique case (cmd)
                clvr_pkg::CMD_TICK:
                begin
                    if (running)
                    begin
                        fc_next = fc_inc;
                        if (!need_div)
                        begin
                            present_next = target_reg;
                        end
                    end
                end
                clvr_pkg::CMD_SET:
                begin
                    // freeze first, then jump or start a ramp
                    start_next  = present_reg;
                    target_next = present_reg;
                    len_next    = '0;
                    fc_next     = '0;
                    if (clamped != present_reg)
                    begin
                        target_next = clamped;
                        if (ramp_frames == '0)
                        begin
                            present_next = clamped;
                        end
                        else
                        begin
                            len_next = ramp_frames;
                        end
                    end
                end
                clvr_pkg::CMD_STOP:
                begin
                    start_next  = present_reg;
                    target_next = present_reg;
                    len_next    = '0;
                    fc_next     = '0;
                end
                clvr_pkg::CMD_RESET:
                begin
                    present_next = rstv_reg;
                    start_next   = rstv_reg;
                    target_next  = rstv_reg;
                    len_next     = '0;
                    fc_next      = '0;
                end
                default:
                begin
                    fc_next = fc_reg;
                end
            endcase
        end
        else if (state_reg == clvr_pkg::ST_CALC && scl_done)
        begin
            present_next = neg ? start_reg - $signed(scl_quot) : start_reg + $signed(scl_quot);
        end
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Serial scaler
    clvr_scale #(
        .VALUE_BITS (VALUE_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scl_start),
        .frame (fc_inc),
        .mag   (mag_full[VALUE_BITS-1:0]),
        .len   (len_reg),
        .done  (scl_done),
        .quot  (scl_quot)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= VALUE_BITS'(clvr_pkg::MIN_RESET);
            max_reg  <= VALUE_BITS'(clvr_pkg::MAX_RESET);
            rstv_reg <= VALUE_BITS'(clvr_pkg::VALUE_RESET);
        end
        else if (cfg_we)
        begin
            unique case (clvr_pkg::reg_idx_t'(cfg_index))
                clvr_pkg::REG_MIN:         min_reg  <= cfg_wdata;
                clvr_pkg::REG_MAX:         max_reg  <= cfg_wdata;
                clvr_pkg::REG_RESET_VALUE: rstv_reg <= cfg_wdata;
                default:                   min_reg  <= min_reg;
            endcase
        end
    end

    // Control and ramp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clvr_pkg::ST_IDLE;
            present_reg   <= VALUE_BITS'(clvr_pkg::VALUE_RESET);
            start_reg     <= VALUE_BITS'(clvr_pkg::VALUE_RESET);
            target_reg    <= VALUE_BITS'(clvr_pkg::VALUE_RESET);
            len_reg       <= '0;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            start_reg     <= start_next;
            target_reg    <= target_next;
            len_reg       <= len_next;
            fc_reg        <= fc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg <= present_reg;
            out_ramp_reg  <= running;
        end
    end

    assign out_valid     = out_valid_reg;
    assign current_value = out_value_reg;
    assign ramping       = out_ramp_reg;

`ifndef NO_ASSERTIONS
    // The scaler only finishes while the controller waits for it
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        scl_done |-> state_reg == clvr_pkg::ST_CALC)
        else $error("scaler finished outside of calculation");

    // A new result only comes from the result state
    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == clvr_pkg::ST_RESULT))
        else $error("result appeared without a result state");

    // A tick with no ramp running leaves the value alone
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == clvr_pkg::CMD_TICK && !running |=> $stable(present_reg))
        else $error("idle tick changed the value");

    // The frame counter never passes the ramp length
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= len_reg)
        else $error("frame count beyond ramp length");
`endif

endmodule

>>> hw/rtl/clvr_scale.sv
// ----------------------------------------------------------------------------
// clvr_scale: bit-serial scaled quotient
// Computes floor(frame * mag / len) for frame < len, one bit of mag per
// cycle, MSB first. Each step folds the next bit into a running remainder
// (radix-2 with quotient digit 0, 1 or 2), so no wide product is formed.
// ----------------------------------------------------------------------------
module clvr_scale #(
    parameter int VALUE_BITS = clvr_pkg::VALUE_BITS_DEF,
    parameter int FRAME_BITS = clvr_pkg::FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FRAME_BITS-1:0] frame,
    input  logic [VALUE_BITS-1:0] mag,
    input  logic [FRAME_BITS-1:0] len,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quot
);

    localparam int CW = $clog2(VALUE_BITS);
    localparam int SW = FRAME_BITS + 2;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [FRAME_BITS-1:0] rem_reg, rem_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [FRAME_BITS-1:0] len_reg, len_next;

    logic [SW-1:0] sum;
    logic [SW-1:0] len1;
    logic [SW-1:0] len2;
    logic [SW-1:0] diff1;
    logic [SW-1:0] diff2;

    // One step: rem = 2*rem + bit*frame, then subtract len up to twice
    always_comb
    begin
        len1  = SW'(len_reg);
        len2  = {1'b0, len_reg, 1'b0};
        sum   = {1'b0, rem_reg, 1'b0} + (mag_reg[VALUE_BITS-1] ? SW'(frame_reg) : '0);
        diff1 = sum - len1;
        diff2 = sum - len2;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        frame_next = frame_reg;
        len_next   = len_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CW'(VALUE_BITS - 1);
            mag_next   = mag;
            quot_next  = '0;
            rem_next   = '0;
            frame_next = frame;
            len_next   = len;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            if (sum >= len2)
            begin
                rem_next  = diff2[FRAME_BITS-1:0];
                quot_next = {quot_reg[VALUE_BITS-2:0], 1'b0} + VALUE_BITS'(2);
            end
            else if (sum >= len1)
            begin
                rem_next  = diff1[FRAME_BITS-1:0];
                quot_next = {quot_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = sum[FRAME_BITS-1:0];
                quot_next = {quot_reg[VALUE_BITS-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        frame_reg <= frame_next;
        len_reg   <= len_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
